[rtl/wbps_pkg.sv]
// shared types and constants for the wildcard byte pattern scanner
package wbps_pkg;

    localparam int CFG_BYTES       = 24;
    localparam int MAX_PATTERN_DEF = 24;
    localparam int OFFSET_BITS_DEF = 32;
    localparam int OUT_W           = 32;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_ADDR_W      = 6;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [2:0] REG_PATTERN_LOW  = 3'd0;
    localparam logic [2:0] REG_PATTERN_MID  = 3'd1;
    localparam logic [2:0] REG_PATTERN_HIGH = 3'd2;
    localparam logic [2:0] REG_CARE_BITS    = 3'd3;
    localparam logic [2:0] REG_PATTERN_LEN  = 3'd4;

    localparam logic [CFG_BYTES-1:0] CARE_RESET = '1;
    localparam logic [4:0]           LEN_RESET  = 5'd24;

    typedef struct packed {
        logic [CFG_BYTES*8-1:0] pattern;
        logic [CFG_BYTES-1:0]   care;
        logic [4:0]             length;
    } cfg_t;

    typedef struct packed {
        logic             hit;
        logic [OUT_W-1:0] start;
        logic             last;
    } scan_ev_t;

endpackage

[rtl/wbps_cfg.sv]
// register file behind the apb configuration port
module wbps_cfg
    import wbps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output cfg_t                  cfg
);

    logic [63:0]          pat_low_reg;
    logic [63:0]          pat_mid_reg;
    logic [63:0]          pat_high_reg;
    logic [CFG_BYTES-1:0] care_reg;
    logic [4:0]           len_reg;
    logic [2:0]           index;
    logic                 wr_en;

    assign index = paddr[CFG_ADDR_W-1:3];
    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_mid_reg  <= '0;
            pat_high_reg <= '0;
            care_reg     <= CARE_RESET;
            len_reg      <= LEN_RESET;
        end
        else if (wr_en)
        begin
            unique case (index)
                REG_PATTERN_LOW:  pat_low_reg  <= pwdata;
                REG_PATTERN_MID:  pat_mid_reg  <= pwdata;
                REG_PATTERN_HIGH: pat_high_reg <= pwdata;
                REG_CARE_BITS:    care_reg     <= pwdata[CFG_BYTES-1:0];
                REG_PATTERN_LEN:  len_reg      <= pwdata[4:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            REG_PATTERN_LOW:  prdata = pat_low_reg;
            REG_PATTERN_MID:  prdata = pat_mid_reg;
            REG_PATTERN_HIGH: prdata = pat_high_reg;
            REG_CARE_BITS:    prdata = CFG_DATA_W'(care_reg);
            REG_PATTERN_LEN:  prdata = CFG_DATA_W'(len_reg);
            default:          prdata = '0;
        endcase
    end

    assign cfg.pattern = {pat_high_reg, pat_mid_reg, pat_low_reg};
    assign cfg.care    = care_reg;
    assign cfg.length  = len_reg;

endmodule

[rtl/wbps_front.sv]
// front end: byte window, offset counter and wildcard compare
module wbps_front
    import wbps_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  logic     in_valid,
    output logic     in_ready,
    input  logic [7:0] data_byte,
    input  logic     byte_readable,
    input  logic     last_byte,
    output logic     ev_valid,
    input  logic     ev_full,
    output scan_ev_t ev
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int EXT   = (MAX_PATTERN > CFG_BYTES) ? MAX_PATTERN : CFG_BYTES;

    logic [7:0]             bytes_reg [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] readable_reg;
    logic [OFFSET_BITS-1:0] pos_reg;

    logic [7:0]             bytes_next [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] readable_next;
    logic [EXT*8-1:0]       pat_ext;
    logic [EXT-1:0]         care_ext;
    logic [LEN_W-1:0]       len;
    logic [LEN_W-1:0]       w;
    logic [IDX_W-1:0]       widx;
    logic                   hit;
    logic [OFFSET_BITS-1:0] start_full;
    logic                   accept;

    assign in_ready = !ev_full;
    assign accept   = in_valid && in_ready;
    assign ev_valid = accept;

    assign pat_ext  = (EXT*8)'(cfg.pattern);
    assign care_ext = EXT'(cfg.care);

    always_comb
    begin
        if (cfg.length == '0)
            len = LEN_W'(1);
        else if (int'(cfg.length) > MAX_PATTERN)
            len = LEN_W'(MAX_PATTERN);
        else
            len = LEN_W'(cfg.length);
    end

    always_comb
    begin
        bytes_next[0]    = data_byte;
        readable_next[0] = byte_readable;
        for (int k = 1; k < MAX_PATTERN; k++)
        begin
            bytes_next[k]    = bytes_reg[k-1];
            readable_next[k] = readable_reg[k-1];
        end
    end

    // pattern byte j lines up with the byte len-1-j places back
    always_comb
    begin
        hit  = 1'b1;
        w    = '0;
        widx = '0;
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            if (j < int'(len))
            begin
                w    = len - LEN_W'(1) - LEN_W'(j);
                widx = IDX_W'(w);
                if (!readable_next[widx])
                    hit = 1'b0;
                if (care_ext[j] && (pat_ext[j*8 +: 8] != bytes_next[widx]))
                    hit = 1'b0;
            end
        end
    end

    assign start_full = pos_reg + OFFSET_BITS'(1) - OFFSET_BITS'(len);

    assign ev.hit   = hit;
    assign ev.start = hit ? OUT_W'(start_full) : '0;
    assign ev.last  = last_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_PATTERN; k++)
                bytes_reg[k] <= '0;
            readable_reg <= '0;
            pos_reg      <= '0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                for (int k = 0; k < MAX_PATTERN; k++)
                    bytes_reg[k] <= '0;
                readable_reg <= '0;
                pos_reg      <= '0;
            end
            else
            begin
                bytes_reg    <= bytes_next;
                readable_reg <= readable_next;
                pos_reg      <= pos_reg + OFFSET_BITS'(1);
            end
        end
    end

endmodule

[rtl/wbps_queue.sv]
// small fifo between the compare front end and the result back end
module wbps_queue
    import wbps_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  scan_ev_t push_ev,
    output logic     full,
    input  logic     pop,
    output scan_ev_t pop_ev,
    output logic     empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    scan_ev_t         slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_ev  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_ev;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

[rtl/wbps_back.sv]
// back end: saturating match count and output register
module wbps_back
    import wbps_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             ev_empty,
    input  scan_ev_t         ev,
    output logic             ev_pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             match_here,
    output logic [OUT_W-1:0] match_start,
    output logic [OUT_W-1:0] match_total,
    output logic             region_done
);

    logic [OUT_W-1:0] count_reg;
    logic [OUT_W-1:0] count_next;
    logic [OUT_W-1:0] total;
    logic             valid_reg;
    logic             here_reg;
    logic [OUT_W-1:0] start_reg;
    logic [OUT_W-1:0] total_reg;
    logic             done_reg;
    logic             load;

    assign load   = !valid_reg || out_ready;
    assign ev_pop = load && !ev_empty;

    always_comb
    begin
        if (ev.hit && (count_reg != '1))
            total = count_reg + OUT_W'(1);
        else
            total = count_reg;
        count_next = ev.last ? '0 : total;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= !ev_empty;
            if (!ev_empty)
                count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ev_pop)
        begin
            here_reg  <= ev.hit;
            start_reg <= ev.start;
            total_reg <= total;
            done_reg  <= ev.last;
        end
    end

    assign out_valid   = valid_reg;
    assign match_here  = here_reg;
    assign match_start = start_reg;
    assign match_total = total_reg;
    assign region_done = done_reg;

endmodule

[rtl/wildcard_byte_pattern_scan_core.sv]
// top level of the wildcard byte pattern scanner
// a taken byte's result is registered in the queue, then in the back end output register
// throughput: one byte per cycle while the queue is not full, limited by the single window compare
// the four-entry queue absorbs short output stalls without stopping input
// reset: rst_n clears window, offset, count and queue at once; registers
// return to pattern zero, all care bits set and length 24
module wildcard_byte_pattern_scan_core
    import wbps_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // data_byte
    input  logic                  s_tuser,   // byte_readable
    input  logic                  s_tlast,   // last_byte
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [2*OUT_W-1:0]    m_tdata,   // match_total, match_start
    output logic                  m_tuser,   // match_here
    output logic                  m_tlast    // region_done
);

    cfg_t             cfg;
    scan_ev_t         push_ev;
    scan_ev_t         pop_ev;
    logic             push;
    logic             full;
    logic             pop;
    logic             empty;
    logic [OUT_W-1:0] match_start;
    logic [OUT_W-1:0] match_total;

    assign pready = 1'b1;

    wbps_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    wbps_front #(
        .MAX_PATTERN (MAX_PATTERN),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .data_byte     (s_tdata),
        .byte_readable (s_tuser),
        .last_byte     (s_tlast),
        .ev_valid      (push),
        .ev_full       (full),
        .ev            (push_ev)
    );

    wbps_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_ev (push_ev),
        .full    (full),
        .pop     (pop),
        .pop_ev  (pop_ev),
        .empty   (empty)
    );

    wbps_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .ev_empty    (empty),
        .ev          (pop_ev),
        .ev_pop      (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .match_here  (m_tuser),
        .match_start (match_start),
        .match_total (match_total),
        .region_done (m_tlast)
    );

    assign m_tdata = {match_total, match_start};

endmodule
